// ===== rtl/hex_loader_command_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Hex loader command parser assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef HEX_LOADER_COMMAND_PARSER_CORE_MACROS_SVH
`define HEX_LOADER_COMMAND_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HLCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hlcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex loader command parser package
// Sizes, field layout, parser modes, event codes and character constants.
// ----------------------------------------------------------------------------
package hlcp_pkg;

	localparam int unsigned CAPACITY = 2048;
	localparam int unsigned SLOTS    = 2;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OFFSET_W = 11;
	localparam int unsigned SIZE_W   = 12;
	localparam int unsigned SLOT_W   = 1;
	localparam int unsigned MASK_W   = 2;
	localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);

	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 40;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_FILE = 3'b010,
		MODE_KILL = 3'b100
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		EV_DATA = 2'd0,
		EV_FILE = 2'd1,
		EV_FULL = 2'd2,
		EV_KILL = 2'd3
	} event_kind_t;

	localparam logic [CHAR_W-1:0] CHAR_OPEN_FILE = 8'h47; // G
	localparam logic [CHAR_W-1:0] CHAR_OPEN_KILL = 8'h4B; // K
	localparam logic [CHAR_W-1:0] CHAR_CLOSE     = 8'h48; // H
	localparam logic [CHAR_W-1:0] CHAR_0         = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9         = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UA        = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UF        = 8'h46;
	localparam logic [CHAR_W-1:0] CHAR_LA        = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h66;
	localparam logic [3:0]        ALPHA_BASE     = 4'd10;

	typedef struct packed {
		logic       is_hex;
		logic       is_digit;
		logic [3:0] nibble;
		logic       is_open_file;
		logic       is_open_kill;
		logic       is_close;
	} char_class_t;

endpackage

// ===== rtl/hlcp_char_decode.sv =====
// ----------------------------------------------------------------------------
// Hex loader character classifier
// Sorts a received character into command letters and hex digit values.
// ----------------------------------------------------------------------------
module hlcp_char_decode (
	input  logic [hlcp_pkg::CHAR_W-1:0] rx_char,
	output hlcp_pkg::char_class_t       cls
);
	import hlcp_pkg::*;

	logic                is_dec;
	logic                is_upper;
	logic                is_lower;
	logic [CHAR_W-1:0]   dec_off;
	logic [CHAR_W-1:0]   upper_off;
	logic [CHAR_W-1:0]   lower_off;

	assign is_dec   = (rx_char >= CHAR_0)  && (rx_char <= CHAR_9);
	assign is_upper = (rx_char >= CHAR_UA) && (rx_char <= CHAR_UF);
	assign is_lower = (rx_char >= CHAR_LA) && (rx_char <= CHAR_LF);

	assign dec_off   = rx_char - CHAR_0;
	assign upper_off = rx_char - CHAR_UA;
	assign lower_off = rx_char - CHAR_LA;

	always_comb begin
		cls              = '0;
		cls.is_digit     = is_dec;
		cls.is_hex       = is_dec || is_upper || is_lower;
		cls.is_open_file = (rx_char == CHAR_OPEN_FILE);
		cls.is_open_kill = (rx_char == CHAR_OPEN_KILL);
		cls.is_close     = (rx_char == CHAR_CLOSE);
		if (is_upper) begin
			cls.nibble = upper_off[3:0] + ALPHA_BASE;
		end else if (is_lower) begin
			cls.nibble = lower_off[3:0] + ALPHA_BASE;
		end else begin
			cls.nibble = dec_off[3:0];
		end
	end

endmodule

// ===== rtl/hex_loader_command_parser_core.sv =====
// ----------------------------------------------------------------------------
// Hex loader command parser core
// Turns received characters into file data bytes, slot claims and kill
// requests, and tracks which slots are in use or asked to stop.
// ----------------------------------------------------------------------------
// A result passes two registers on its way to the output: the input register,
// then the result register.
// Throughput: one input transfer per cycle while the output is not stalled;
// the combinational parser update between the two registers allows this.
// Reset (arst_n low): idle mode, no pending nibble, zero count, all slots
// free with no stop request, both registers empty.
module hex_loader_command_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] rx_char, [8] released_slot, [15:9] zero
	input  logic [hlcp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [0] operation
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] data_byte, [18:8] byte_offset, [30:19] file_len,
	// [31] slot_index, [33:32] stop_mask, [39:34] zero
	output logic [hlcp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// [1:0] event_kind
	output logic [hlcp_pkg::KIND_W-1:0]     m_axis_tuser
);
	import hlcp_pkg::*;

	// input register
	logic              valid_s1;
	logic              op_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [SLOT_W-1:0] rel_s1;

	// parser state
	mode_t              mode_q,   mode_d;
	logic               pend_q,   pend_d;
	logic [3:0]         hi_q,     hi_d;
	logic [COUNT_W-1:0] count_q,  count_d;
	logic [SLOTS-1:0]   busy_q,   busy_d;
	logic [SLOTS-1:0]   stop_q,   stop_d;

	// result register
	logic                out_valid_q;
	event_kind_t         out_kind_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [SIZE_W-1:0]   out_size_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [MASK_W-1:0]   out_mask_q;

	// next result
	logic                res_valid;
	event_kind_t         res_kind;
	logic [BYTE_W-1:0]   res_byte;
	logic [OFFSET_W-1:0] res_off;
	logic [SIZE_W-1:0]   res_size;
	logic [SLOT_W-1:0]   res_slot;

	logic              advance;
	logic              in_xfer;
	char_class_t       cls;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] kill_idx;
	logic              kill_hit;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	hlcp_char_decode u_char_decode (
		.rx_char (char_s1),
		.cls     (cls)
	);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign kill_idx = cls.nibble[SLOT_W-1:0];
	assign kill_hit = cls.is_digit && (32'(cls.nibble) < SLOTS) && busy_q[kill_idx];

	always_comb begin
		mode_d    = mode_q;
		pend_d    = pend_q;
		hi_d      = hi_q;
		count_d   = count_q;
		busy_d    = busy_q;
		stop_d    = stop_q;
		res_valid = 1'b0;
		res_kind  = EV_DATA;
		res_byte  = '0;
		res_off   = '0;
		res_size  = '0;
		res_slot  = '0;
		if (op_s1) begin
			if (32'(rel_s1) < SLOTS) begin
				busy_d[rel_s1] = 1'b0;
			end
		end else begin
			unique case (mode_q)
				MODE_KILL: begin
					mode_d = MODE_IDLE;
					if (kill_hit) begin
						stop_d[kill_idx] = 1'b1;
						res_valid        = 1'b1;
						res_kind         = EV_KILL;
						res_slot         = kill_idx;
					end
				end
				MODE_FILE: begin
					if (cls.is_close) begin
						mode_d = MODE_IDLE;
						pend_d = 1'b0;
						if (count_q != '0) begin
							res_valid = 1'b1;
							res_size  = SIZE_W'(count_q);
							if (free_found) begin
								busy_d[free_idx] = 1'b1;
								stop_d[free_idx] = 1'b0;
								res_kind         = EV_FILE;
								res_slot         = free_idx;
							end else begin
								res_kind = EV_FULL;
							end
						end
					end else if (cls.is_hex) begin
						if (!pend_q) begin
							hi_d   = cls.nibble;
							pend_d = 1'b1;
						end else begin
							pend_d = 1'b0;
							// drop bytes past capacity, count saturates
							if (count_q < COUNT_W'(CAPACITY)) begin
								count_d   = count_q + 1'b1;
								res_valid = 1'b1;
								res_kind  = EV_DATA;
								res_byte  = {hi_q, cls.nibble};
								res_off   = OFFSET_W'(count_q);
							end
						end
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					if (cls.is_open_file) begin
						mode_d  = MODE_FILE;
						count_d = '0;
						pend_d  = 1'b0;
					end else if (cls.is_open_kill) begin
						mode_d = MODE_KILL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= s_axis_tuser;
			char_s1 <= s_axis_tdata[CHAR_W-1:0];
			rel_s1  <= s_axis_tdata[CHAR_W +: SLOT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= 1'b0;
			hi_q    <= '0;
			count_q <= '0;
			busy_q  <= '0;
			stop_q  <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			hi_q    <= hi_d;
			count_q <= count_d;
			busy_q  <= busy_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			out_off_q  <= res_off;
			out_size_q <= res_size;
			out_slot_q <= res_slot;
			out_mask_q <= MASK_W'(stop_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = M_TDATA_W'({out_mask_q, out_slot_q, out_size_q, out_off_q,
		out_byte_q});

endmodule

// ===== rtl/hlcp_checker.sv =====
// ----------------------------------------------------------------------------
// Hex loader command parser port checker
// Watches the result stream for handshake and event consistency.
// ----------------------------------------------------------------------------
`include "hex_loader_command_parser_core_macros.svh"

module hlcp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [hlcp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [hlcp_pkg::KIND_W-1:0]     m_axis_tuser
);
	import hlcp_pkg::*;

	logic        is_data;
	logic        is_claim;
	logic        is_kill;
	logic [11:0] size_f;
	logic        slot_f;
	logic [1:0]  mask_f;

	assign is_data  = m_axis_tvalid && (m_axis_tuser == EV_DATA);
	assign is_claim = m_axis_tvalid && ((m_axis_tuser == EV_FILE) || (m_axis_tuser == EV_FULL));
	assign is_kill  = m_axis_tvalid && (m_axis_tuser == EV_KILL);
	assign size_f   = m_axis_tdata[30:19];
	assign slot_f   = m_axis_tdata[31];
	assign mask_f   = m_axis_tdata[33:32];

	// stalled transfer keeps its payload
	`HLCP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result changed while stalled")

	`HLCP_ASSERT_NOW(a_data_clean, clk, arst_n, is_data,
		(size_f == '0) && (slot_f == 1'b0), "data byte carries size or slot")

	`HLCP_ASSERT_NOW(a_claim_size, clk, arst_n, is_claim,
		(size_f != '0) && (m_axis_tdata[18:0] == '0), "file end without size")

	`HLCP_ASSERT_NOW(a_kill_mask, clk, arst_n, is_kill,
		mask_f[slot_f], "kill without stop flag")

	`HLCP_ASSERT_NOW(a_claim_mask, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == EV_FILE), !mask_f[slot_f],
		"claimed slot still asked to stop")

endmodule

bind hex_loader_command_parser_core hlcp_checker u_hlcp_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Hex loader command parser testbench
// Sends characters and slot releases over the input stream and predicts
// every data, slot claim, full and kill event in a scoreboard. Each event
// on the output stream is compared field by field with the oldest
// prediction. Both streams idle at random except near the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import hlcp_pkg::*;

	localparam int unsigned ITEMS      = 1750;
	localparam int unsigned CALM_ITEMS = 150;

	typedef struct {
		event_kind_t         kind;
		logic [BYTE_W-1:0]   data_byte;
		logic [OFFSET_W-1:0] byte_offset;
		logic [SIZE_W-1:0]   file_len;
		logic [SLOT_W-1:0]   slot_index;
		logic [MASK_W-1:0]   stop_mask;
	} loader_event_t;

	class parser_scoreboard;
		mode_t              mode;
		bit                 nibble_held;
		logic [3:0]         upper_nibble;
		int unsigned        stored_bytes;
		logic [SLOTS-1:0]   slot_busy;
		logic [SLOTS-1:0]   slot_stop;
		loader_event_t      expected_events[$];
		int unsigned        mismatches;

		function new();
			mode         = MODE_IDLE;
			nibble_held  = 1'b0;
			upper_nibble = '0;
			stored_bytes = 0;
			slot_busy    = '0;
			slot_stop    = '0;
			mismatches   = 0;
		endfunction

		function int hex_digit(logic [CHAR_W-1:0] ch);
			if (ch >= CHAR_0 && ch <= CHAR_9)
				return int'(ch - CHAR_0);
			if (ch >= CHAR_UA && ch <= CHAR_UF)
				return int'(ch - CHAR_UA) + ALPHA_BASE;
			if (ch >= CHAR_LA && ch <= CHAR_LF)
				return int'(ch - CHAR_LA) + ALPHA_BASE;
			return -1;
		endfunction

		function void queue_event(event_kind_t kind, logic [BYTE_W-1:0] data,
				logic [OFFSET_W-1:0] offset, logic [SIZE_W-1:0] size,
				logic [SLOT_W-1:0] slot);
			loader_event_t ev;
			ev.kind        = kind;
			ev.data_byte   = data;
			ev.byte_offset = offset;
			ev.file_len    = size;
			ev.slot_index  = slot;
			ev.stop_mask   = slot_stop;
			expected_events.push_back(ev);
		endfunction

		function void note_transfer(logic op, logic [CHAR_W-1:0] ch, logic rel);
			int digit;
			int slot;
			bit claimed;
			if (op) begin
				if (rel < SLOTS)
					slot_busy[rel] = 1'b0;
				return;
			end
			case (mode)
				MODE_KILL: begin
					mode = MODE_IDLE;
					if (ch >= CHAR_0 && ch <= CHAR_9) begin
						slot = int'(ch - CHAR_0);
						if (slot < SLOTS && slot_busy[slot]) begin
							slot_stop[slot] = 1'b1;
							queue_event(EV_KILL, '0, '0, '0, SLOT_W'(slot));
						end
					end
				end
				MODE_FILE: begin
					if (ch == CHAR_CLOSE) begin
						mode        = MODE_IDLE;
						nibble_held = 1'b0;
						if (stored_bytes == 0)
							return;
						claimed = 1'b0;
						for (slot = 0; slot < SLOTS && !claimed; slot++) begin
							if (!slot_busy[slot]) begin
								slot_busy[slot] = 1'b1;
								slot_stop[slot] = 1'b0;
								claimed         = 1'b1;
								queue_event(EV_FILE, '0, '0, SIZE_W'(stored_bytes),
									SLOT_W'(slot));
							end
						end
						if (!claimed)
							queue_event(EV_FULL, '0, '0, SIZE_W'(stored_bytes), '0);
						return;
					end
					digit = hex_digit(ch);
					if (digit < 0)
						return;
					if (!nibble_held) begin
						upper_nibble = 4'(digit);
						nibble_held  = 1'b1;
						return;
					end
					nibble_held = 1'b0;
					// past capacity the pair is consumed but nothing is stored
					if (stored_bytes < CAPACITY) begin
						queue_event(EV_DATA, {upper_nibble, 4'(digit)},
							OFFSET_W'(stored_bytes), '0, '0);
						stored_bytes++;
					end
				end
				default: begin
					mode = MODE_IDLE;
					if (ch == CHAR_OPEN_FILE) begin
						mode         = MODE_FILE;
						stored_bytes = 0;
						nibble_held  = 1'b0;
					end else if (ch == CHAR_OPEN_KILL) begin
						mode = MODE_KILL;
					end
				end
			endcase
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_event(logic [M_TDATA_W-1:0] tdata, logic [KIND_W-1:0] tuser);
			loader_event_t ev;
			if (expected_events.size() == 0) begin
				$error("unexpected event: kind %0d, tdata %h", tuser, tdata);
				mismatches++;
				return;
			end
			ev = expected_events.pop_front();
			check_field("event_kind", ev.kind, tuser);
			check_field("data_byte", ev.data_byte, tdata[7:0]);
			check_field("byte_offset", ev.byte_offset, tdata[18:8]);
			check_field("file_len", ev.file_len, tdata[30:19]);
			check_field("slot_index", ev.slot_index, tdata[31]);
			check_field("stop_mask", ev.stop_mask, tdata[33:32]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic [KIND_W-1:0]      m_axis_tuser;

	parser_scoreboard       board = new();
	bit                     calm = 1'b0;
	int unsigned            useful_items = 0;

	hex_loader_command_parser_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(logic op, logic [CHAR_W-1:0] ch, logic rel, bit ignored = 1'b0);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(S_TDATA_W - CHAR_W - 1){1'b0}}, rel, ch};
		do @(posedge clk); while (!s_axis_tready);
		board.note_transfer(op, ch, rel);
		if (!ignored)
			useful_items++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_char(logic [CHAR_W-1:0] ch, bit ignored = 1'b0);
		send_item(1'b0, ch, 1'($urandom), ignored);
	endtask

	task automatic send_release(logic slot);
		send_item(1'b1, 8'($urandom), slot);
	endtask

	function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] nib);
		if (nib < ALPHA_BASE)
			return CHAR_0 + nib;
		return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + nib - ALPHA_BASE;
	endfunction

	function automatic logic [CHAR_W-1:0] non_hex_char();
		logic [CHAR_W-1:0] ch;
		do ch = 8'($urandom); while (board.hex_digit(ch) >= 0 || ch == CHAR_CLOSE);
		return ch;
	endfunction

	task automatic send_file(int unsigned length, bit odd_tail);
		logic [BYTE_W-1:0] value;
		send_char(CHAR_OPEN_FILE);
		for (int unsigned i = 0; i < length; i++) begin
			value = 8'($urandom);
			if ($urandom_range(0, 7) == 0)
				send_char(non_hex_char(), 1'b1);
			send_char(hex_char(value[7:4]));
			send_char(hex_char(value[3:0]));
		end
		if (odd_tail)
			send_char(hex_char(4'($urandom)));
		send_char(CHAR_CLOSE);
	endtask

	// output side: random back-pressure bursts until the calm tail
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_event(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		int unsigned pick;
		logic [CHAR_W-1:0] ch;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle noise, kill of a free slot, a mixed-case file with noise
		// and a dropped odd digit, empty file, second slot, full, kills, releases
		send_char("A", 1'b1);
		send_char(CHAR_OPEN_KILL);
		send_char("0");
		send_char(CHAR_OPEN_FILE);
		send_char("0");
		send_char("0");
		send_char("f");
		send_char("F");
		send_char("x", 1'b1);
		send_char(CHAR_OPEN_KILL, 1'b1);
		send_char("9");
		send_char("a");
		send_char("7");
		send_char(CHAR_CLOSE);
		send_char(CHAR_OPEN_FILE);
		send_char(CHAR_CLOSE);
		send_file(1, 1'b0);
		send_file(1, 1'b0);
		send_char(CHAR_OPEN_KILL);
		send_char("1");
		send_char(CHAR_OPEN_KILL);
		send_char("0");
		send_char(CHAR_OPEN_KILL);
		send_char("Z");
		send_char(CHAR_OPEN_KILL);
		send_char("5");
		send_release(1'b0);
		send_release(1'b1);

		// fill to capacity and beyond: the last pairs are dropped
		send_file(CAPACITY + 3, 1'b1);

		while (useful_items < ITEMS + CAPACITY * 2) begin
			if (useful_items >= ITEMS + CAPACITY * 2 - CALM_ITEMS)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_file(($urandom_range(0, 39) == 0) ? $urandom_range(13, 60)
					: $urandom_range(0, 12), $urandom_range(0, 3) == 0);
			end else if (pick < 75) begin
				send_char(CHAR_OPEN_KILL);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_char(CHAR_0 + 8'($urandom_range(0, SLOTS - 1)));
				else if (pick < 85)
					send_char(CHAR_0 + 8'($urandom_range(SLOTS, 9)));
				else
					send_char(8'($urandom));
			end else if (pick < 90) begin
				send_release(1'($urandom));
			end else begin
				ch = 8'($urandom);
				send_char(ch, ch != CHAR_OPEN_FILE && ch != CHAR_OPEN_KILL);
			end
		end
		// close any file or kill left open by stray idle noise
		send_char(CHAR_CLOSE);
		s_axis_tvalid <= 1'b0;

		while (board.expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.expected_events.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
